// ===== hdl/ipd_pkg.sv =====
`default_nettype none

package ipd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 8;
  localparam int unsigned CODE_BITS_DEFAULT   = 32;
  localparam int unsigned OP_FIFO_DEPTH       = 4;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OUT_CODE_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MODE = 3'd5;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [MODE_W-1:0] MODE_ALL_EDGES = 2'd2;

  // what the back end has to do for one item
  typedef struct packed {
    logic push;
    logic pop;
  } op_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ipd_front.sv =====
`default_nettype none

module ipd_front import ipd_pkg::*; #(
  parameter int unsigned CODE_BITS = CODE_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 accept,
  input  wire logic                 command,
  input  wire logic [TIME_W-1:0]    timestamp_us,
  input  wire logic                 line_level,
  output op_ctl_t                   op_ctl,
  output logic [CODE_BITS-1:0]      op_code,
  output logic                      op_write
);

  logic [TIME_W-1:0]    zero_min, zero_max, one_min, one_max, start_gap;
  logic [MODE_W-1:0]    signal_mode;
  logic [CODE_BITS-1:0] shift_code, shift_code_next;
  logic [TIME_W-1:0]    prev_time, prev_time_next;

  logic [TIME_W-1:0]    interval;
  logic                 is_edge, qualify, long_gap, finish, in_zero, in_one;
  logic [CODE_BITS-1:0] shift_base;

  always_comb begin
    interval = timestamp_us - prev_time;
    is_edge  = (command == CMD_EDGE);
    // modes 0 and 1 skip edges that land on the configured level
    qualify  = is_edge && !(!signal_mode[1] && line_level == signal_mode[0]);
    long_gap = interval > start_gap;
    if (is_edge) begin
      finish = qualify && long_gap && (shift_code != '0);
    end else begin
      finish = long_gap;
    end
    in_zero = (interval >= zero_min) && (interval <= zero_max);
    in_one  = (interval >= one_min) && (interval <= one_max);
    shift_base = finish ? '0 : shift_code;
    shift_code_next = shift_base;
    if (qualify) begin
      if (in_zero) begin
        shift_code_next = {shift_base[CODE_BITS-2:0], 1'b0};
      end else if (in_one) begin
        shift_code_next = {shift_base[CODE_BITS-2:0], 1'b1};
      end
    end
    prev_time_next = is_edge ? timestamp_us : prev_time;
    op_ctl.push = finish;
    op_ctl.pop  = !is_edge;
    op_code     = shift_code;
    op_write    = accept && (finish || !is_edge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_min    <= '0;
      zero_max    <= '0;
      one_min     <= '0;
      one_max     <= '0;
      start_gap   <= '0;
      signal_mode <= MODE_ALL_EDGES;
      shift_code  <= '0;
      prev_time   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ZERO_MIN:    zero_min    <= cfg_data;
          REG_ZERO_MAX:    zero_max    <= cfg_data;
          REG_ONE_MIN:     one_min     <= cfg_data;
          REG_ONE_MAX:     one_max     <= cfg_data;
          REG_START_GAP:   start_gap   <= cfg_data;
          REG_SIGNAL_MODE: signal_mode <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        shift_code <= shift_code_next;
        prev_time  <= prev_time_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipd_op_fifo.sv =====
`default_nettype none

module ipd_op_fifo import ipd_pkg::*; #(
  parameter int unsigned WIDTH = CODE_BITS_DEFAULT + 2,
  parameter int unsigned DEPTH = OP_FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty,
  output logic                  full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipd_back.sv =====
`default_nettype none

module ipd_back import ipd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  parameter int unsigned CODE_BITS   = CODE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  op_avail,
  input  wire op_ctl_t               op_ctl,
  input  wire logic [CODE_BITS-1:0]  op_code,
  output logic                       op_take,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_CODE_W-1:0]      code,
  output logic                       code_valid
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);

  logic [CODE_BITS-1:0] code_queue [QUEUE_DEPTH];
  logic [SLOT_W-1:0]    write_slot, read_slot;
  logic [CODE_BITS-1:0] entry;
  logic                 entry_valid;

  logic [SLOT_W-1:0] write_after, pop_slot;
  logic              do_push, do_pop, out_free;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    out_free    = !out_valid || !out_stall;
    op_take     = op_avail && (!op_ctl.pop || out_free);
    // queue is full when the write slot has caught up with the read slot
    do_push     = op_take && op_ctl.push && (write_slot != read_slot);
    write_after = do_push ? next_slot(write_slot) : write_slot;
    pop_slot    = next_slot(read_slot);
    do_pop      = op_take && op_ctl.pop && (pop_slot != write_after);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      code_queue[write_slot] <= op_code;
    end
    if (op_take && op_ctl.pop) begin
      // a code pushed by this same beat is forwarded past the memory
      if (do_push && pop_slot == write_slot) begin
        entry <= op_code;
      end else begin
        entry <= code_queue[pop_slot];
      end
      entry_valid <= do_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= SLOT_W'(1);
      read_slot  <= '0;
      out_valid  <= 1'b0;
    end else begin
      write_slot <= write_after;
      if (do_pop) begin
        read_slot <= pop_slot;
      end
      if (op_take && op_ctl.pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign code       = entry_valid ? OUT_CODE_W'(entry) : '0;
  assign code_valid = entry_valid;

endmodule

`default_nettype wire

// ===== hdl/ir_pulse_width_decoder_fifo_top.sv =====
// ir pulse-distance decoder with a queue of finished codes
//
// input channel (in_valid / in_stall): one beat per event. command edge
// carries the receiver line level and a microsecond timestamp; command read
// asks for the oldest queued code. edges give no output, each read gives
// exactly one output beat (code, code_valid) on the output channel.
// configuration: cfg_write with cfg_index / cfg_data, one register per cycle,
// written only while the block is idle, a rule for the user that the block does not enforce.
// throughput: one input beat per cycle while in_stall is low. the front end decodes an edge in the
// cycle it is accepted, and a small op queue feeds the back end, which does
// one queue push and one pop per cycle while the output is not stalled, on a single memory
// write port and a registered read port.
// with nothing queued ahead, a read's beat is registered in the op queue, and its result
// is then registered in the output register that drives code and code_valid.
// when the receiver stalls, the result holds in the output register; the
// op queue keeps filling and in_stall rises once its four slots are full.
// reset (rst, synchronous): windows and start gap clear, signal mode
// becomes every edge, the code queue is empty, no output is pending.
`default_nettype none

module ir_pulse_width_decoder_fifo_top import ipd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  parameter int unsigned CODE_BITS   = CODE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  command,
  input  wire logic [TIME_W-1:0]     timestamp_us,
  input  wire logic                  line_level,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_CODE_W-1:0]      code,
  output logic                       code_valid
);

  localparam int unsigned OP_W = CODE_BITS + $bits(op_ctl_t);

  op_ctl_t              front_ctl, back_ctl;
  logic [CODE_BITS-1:0] front_code, back_code;
  logic                 front_write, fifo_empty, fifo_full, back_take;
  logic                 accept;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  ipd_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .command      (command),
    .timestamp_us (timestamp_us),
    .line_level   (line_level),
    .op_ctl       (front_ctl),
    .op_code      (front_code),
    .op_write     (front_write)
  );

  ipd_op_fifo #(
    .WIDTH(OP_W),
    .DEPTH(OP_FIFO_DEPTH)
  ) u_op_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_write),
    .wr_data ({front_ctl, front_code}),
    .rd_en   (back_take),
    .rd_data ({back_ctl, back_code}),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  ipd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .CODE_BITS  (CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_avail   (!fifo_empty),
    .op_ctl     (back_ctl),
    .op_code    (back_code),
    .op_take    (back_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code),
    .code_valid (code_valid)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ipd_pkg::*;

  localparam int unsigned QDEPTH        = QUEUE_DEPTH_DEFAULT;
  localparam int unsigned CBITS         = CODE_BITS_DEFAULT;
  localparam int unsigned PHASE_BEATS   = 200;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  localparam logic [MODE_W-1:0] LEVEL_MODE_LOW  = 2'd0;
  localparam logic [MODE_W-1:0] LEVEL_MODE_HIGH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVERY_ALT  = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] ts;
    logic              lvl;
  } ir_beat_t;

  typedef struct packed {
    logic [OUT_CODE_W-1:0] code;
    logic                  valid;
  } code_beat_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_ZERO_MIN;
  logic [CFG_W-1:0]      cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  command      = CMD_EDGE;
  logic [TIME_W-1:0]     timestamp_us = '0;
  logic                  line_level   = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [OUT_CODE_W-1:0] code;
  logic                  code_valid;

  ir_pulse_width_decoder_fifo_top #(
    .QUEUE_DEPTH(QDEPTH),
    .CODE_BITS  (CBITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .timestamp_us(timestamp_us),
    .line_level  (line_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code        (code),
    .code_valid  (code_valid)
  );

  // decoder copy: settings and state
  logic [31:0]       zero_lo, zero_hi, one_lo, one_hi, gap_limit;
  logic [MODE_W-1:0] level_mode;
  logic [CBITS-1:0]  code_acc;
  logic [TIME_W-1:0] last_edge_us;
  logic [CBITS-1:0]  code_ring [QDEPTH];
  int unsigned       wr_slot, rd_slot;

  ir_beat_t    pending_beats [$];
  code_beat_t  expected_codes [$];
  int unsigned beats_total = 0;
  int unsigned beats_done  = 0;
  int unsigned phase_beats = 0;
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  logic        steady_flow = 1'b0;
  logic [31:0] clock_us    = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic store_code();
    // full ring drops the code, the shift register clears anyway
    if (wr_slot != rd_slot) begin
      code_ring[wr_slot] = code_acc;
      wr_slot = (wr_slot + 1) % QDEPTH;
    end
    code_acc = '0;
  endtask

  task automatic decode_step(input logic cmd, input logic [TIME_W-1:0] ts, input logic lvl);
    logic [TIME_W-1:0] span;
    int unsigned       next_rd;
    code_beat_t        res;
    span = ts - last_edge_us;
    if (cmd == CMD_EDGE) begin
      if (!(level_mode < MODE_ALL_EDGES && lvl == level_mode[0])) begin
        if (span > gap_limit && code_acc != '0) store_code();
        if (span >= zero_lo && span <= zero_hi) code_acc = code_acc << 1;
        else if (span >= one_lo && span <= one_hi) code_acc = {code_acc[CBITS-2:0], 1'b1};
      end
      last_edge_us = ts;
    end else begin
      // a read after a long gap flushes even an empty code
      if (span > gap_limit) store_code();
      next_rd = (rd_slot + 1) % QDEPTH;
      res = '0;
      if (next_rd != wr_slot) begin
        res.code  = code_ring[next_rd];
        res.valid = 1'b1;
        code_ring[next_rd] = '0;
        rd_slot = next_rd;
      end
      expected_codes.push_back(res);
    end
  endtask

  // input side
  always @(posedge clk) begin : drive_beats
    ir_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_step(command, timestamp_us, line_level);
        beats_done++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (steady_flow || $urandom_range(99, 0) >= 19)) begin
          nb = pending_beats.pop_front();
          in_valid     <= 1'b1;
          command      <= nb.cmd;
          timestamp_us <= nb.ts;
          line_level   <= nb.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin : watch_codes
    code_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          flag_mismatch($sformatf("code beat with none pending: code %h valid %b",
                                  code, code_valid));
        end else begin
          want = expected_codes.pop_front();
          if (code !== want.code)
            flag_mismatch($sformatf("code: got %h, want %h", code, want.code));
          if (code_valid !== want.valid)
            flag_mismatch($sformatf("code_valid: got %b, want %b", code_valid, want.valid));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
        out_stall  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(99, 0) < 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic setup(input logic [31:0] zl, input logic [31:0] zh, input logic [31:0] ol,
                       input logic [31:0] oh, input logic [31:0] gl,
                       input logic [MODE_W-1:0] md);
    write_reg(REG_ZERO_MIN, zl);
    write_reg(REG_ZERO_MAX, zh);
    write_reg(REG_ONE_MIN, ol);
    write_reg(REG_ONE_MAX, oh);
    write_reg(REG_START_GAP, gl);
    write_reg(REG_SIGNAL_MODE, md);
    @(posedge clk);
    cfg_write <= 1'b0;
    zero_lo    = zl;
    zero_hi    = zh;
    one_lo     = ol;
    one_hi     = oh;
    gap_limit  = gl;
    level_mode = md;
    phase_beats = 0;
  endtask

  task automatic wait_idle();
    while (beats_done != beats_total || expected_codes.size() != 0) @(posedge clk);
    // edges leave no result, give the back end time to settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_beat(input logic cmd, input logic [31:0] ts, input logic lvl);
    ir_beat_t b;
    b.cmd = cmd;
    b.ts  = ts;
    b.lvl = lvl;
    pending_beats.push_back(b);
    beats_total++;
    phase_beats++;
  endtask

  task automatic add_edge(input logic [31:0] delta, input logic lvl);
    clock_us = clock_us + delta;
    push_beat(CMD_EDGE, clock_us, lvl);
  endtask

  function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
    if (lo == 0 && hi == ALL_ONES) return $urandom;
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom;
  endfunction

  function automatic logic [31:0] long_gap();
    if (gap_limit > 32'hFFFF_0000) return $urandom;
    return gap_limit + 1 + $urandom_range(3000, 0);
  endfunction

  task automatic add_frame(input int nbits);
    logic        lvl;
    logic [31:0] gapv;
    lvl = (level_mode < MODE_ALL_EDGES) ? !level_mode[0] : 1'($urandom_range(1, 0));
    add_edge(long_gap(), lvl);
    for (int i = 0; i < nbits; i++) begin
      // in a level mode each bit is a mark edge that is skipped, then a measured space
      if (level_mode < MODE_ALL_EDGES) add_edge(pick(50, 300), level_mode[0]);
      else lvl = !lvl;
      if ($urandom_range(19, 0) == 0) gapv = $urandom_range(3000, 0);
      else if ($urandom_range(1, 0) != 0) gapv = pick(one_lo, one_hi);
      else gapv = pick(zero_lo, zero_hi);
      add_edge(gapv, lvl);
    end
  endtask

  task automatic add_reads(input int count);
    logic [31:0] ts;
    for (int i = 0; i < count; i++) begin
      ts = clock_us + (($urandom_range(1, 0) != 0) ? long_gap() : $urandom_range(200, 0));
      push_beat(CMD_READ, ts, 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic run_traffic();
    int unsigned act;
    while (phase_beats < PHASE_BEATS) begin
      act = $urandom_range(99, 0);
      if (act < 40) begin
        add_frame(($urandom_range(9, 0) == 0) ? $urandom_range(40, 33) : $urandom_range(24, 1));
      end else if (act < 50) begin
        clock_us = $urandom;
        push_beat(CMD_EDGE, clock_us, 1'($urandom_range(1, 0)));
      end else begin
        add_reads($urandom_range(4, 1));
      end
    end
  endtask

  initial begin
    logic [31:0] zl, zh, ol, oh, gl;
    zero_lo = '0;
    zero_hi = '0;
    one_lo = '0;
    one_hi = '0;
    gap_limit = '0;
    level_mode = MODE_ALL_EDGES;
    code_acc = '0;
    last_edge_us = '0;
    foreach (code_ring[i]) code_ring[i] = '0;
    wr_slot = 1 % QDEPTH;
    rd_slot = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty read, zero interval, wrap, flush of an empty code, full ring
    setup(32'd0, 32'd10, 32'd11, 32'd20, 32'd100, MODE_ALL_EDGES);
    push_beat(CMD_READ, 32'h0000_0000, 1'b1);
    push_beat(CMD_EDGE, 32'h0000_0000, 1'b1);
    push_beat(CMD_EDGE, 32'h0000_000F, 1'b0);
    push_beat(CMD_EDGE, 32'h0000_0014, 1'b1);
    push_beat(CMD_EDGE, ALL_ONES, 1'b0);
    push_beat(CMD_EDGE, 32'h0000_000A, 1'b1);
    push_beat(CMD_READ, 32'h0000_0100, 1'b0);
    push_beat(CMD_READ, 32'h0000_010B, 1'b1);
    push_beat(CMD_READ, 32'h0000_000A, 1'b0);
    push_beat(CMD_READ, 32'h0000_000A, 1'b1);
    clock_us = 32'h0000_000A;
    repeat (8) begin
      add_edge(32'd15, 1'b0);
      add_edge(32'd200, 1'b1);
    end
    wait_idle();

    // a stretch with no idling on either side
    steady_flow = 1'b1;
    setup(32'd400, 32'd700, 32'd1400, 32'd1800, 32'd4000, MODE_ALL_EDGES);
    run_traffic();
    wait_idle();
    steady_flow = 1'b0;

    setup(32'd300, 32'd800, 32'd1200, 32'd2000, 32'd5000, LEVEL_MODE_LOW);
    run_traffic();
    wait_idle();

    // receiver holds off while reads pile up behind it
    setup(32'd300, 32'd800, 32'd1200, 32'd2000, 32'd5000, LEVEL_MODE_HIGH);
    holds_asked++;
    add_reads(12);
    run_traffic();
    wait_idle();

    // overlapping windows, zero window wins
    setup(32'd500, 32'd1500, 32'd1000, 32'd2500, 32'd6000, MODE_EVERY_ALT);
    run_traffic();
    wait_idle();

    // zero window with min above max
    setup(32'd900, 32'd400, 32'd1200, 32'd2000, 32'd5000, MODE_ALL_EDGES);
    run_traffic();
    wait_idle();

    setup(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, LEVEL_MODE_LOW);
    run_traffic();
    wait_idle();

    setup(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, MODE_ALL_EDGES);
    run_traffic();
    wait_idle();

    setup($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom_range(3, 0)));
    run_traffic();
    wait_idle();

    zl = $urandom_range(600, 100);
    zh = zl + $urandom_range(400, 0);
    ol = zh + $urandom_range(800, 1);
    oh = ol + $urandom_range(800, 0);
    gl = oh + $urandom_range(5000, 1);
    setup(zl, zh, ol, oh, gl, 2'($urandom_range(3, 0)));
    holds_asked++;
    add_reads(12);
    run_traffic();
    wait_idle();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ipd_pkg.sv
hdl/ipd_front.sv
hdl/ipd_op_fifo.sv
hdl/ipd_back.sv
hdl/ir_pulse_width_decoder_fifo_top.sv
tb/tb_top.sv
